FILE: src/fbfla_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbfla_pkg: shared constants and types of the block free-list allocator
// Sizes, status codes, register indexes and controller/datapath structs.
// ---------------------------------------------------------------------------
package fbfla_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS   = 1024;
  localparam int POOL_ID_BITS = 8;

  // Field widths
  localparam int IDX_W  = $clog2(NUM_BLOCKS);   // block index
  localparam int CNT_W  = IDX_W + 1;            // counts and end mark
  localparam int POOL_W = 8;                    // pool id field
  localparam int STAT_W = 3;
  localparam int CFG_DW = 11;                   // widest config register
  localparam int CFG_AW = 1;

  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(NUM_BLOCKS);
  localparam logic [POOL_W-1:0] POOL_MASK = POOL_W'((1 << POOL_ID_BITS) - 1);

  // Request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_WRONG_ID  = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_INIT  = 3'd4;

  // Config register indexes
  localparam logic [CFG_AW-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_POOL_ID     = 1'd1;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // execute it and fill the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } dp_stat_t;

endpackage

FILE: src/fbfla_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbfla channel interfaces
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface fbfla_req_if
  import fbfla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  block_index;
  logic [POOL_W-1:0] owner_pool;

  modport source (output valid, req_type, block_index, owner_pool, input ready);
  modport sink   (input valid, req_type, block_index, owner_pool, output ready);
endinterface

interface fbfla_rsp_if
  import fbfla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  granted_index;
  logic [POOL_W-1:0] granted_pool;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, status, granted_index, granted_pool, free_count,
                  input ready);
  modport sink   (input valid, status, granted_index, granted_pool, free_count,
                  output ready);
endinterface

FILE: src/fbfla_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbfla_ctrl: request sequencer
// Accepts one item, waits for the link read, then executes it once the
// output register can take the result.
// ---------------------------------------------------------------------------
module fbfla_ctrl
  import fbfla_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // link read data is ready here; hold until the result slot frees
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/fbfla_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbfla_dp: free-list datapath
// Head, fresh mark, free count, config registers, link memory and the
// output register.
// ---------------------------------------------------------------------------
module fbfla_dp
  import fbfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  // captured request
  input  logic              in_req_type,
  input  logic [IDX_W-1:0]  in_block_index,
  input  logic [POOL_W-1:0] in_owner_pool,
  // config
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // result
  input  logic              out_ready,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic [POOL_W-1:0] out_granted_pool,
  output logic [CNT_W-1:0]  out_free_count
);

  // Link memory: one more bit than an index so it can hold the end mark
  logic [CNT_W-1:0] link_mem [NUM_BLOCKS];
  logic [CNT_W-1:0] rd_link_r;

  // Allocator state and config
  logic [CNT_W-1:0]  head_r,  head_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  rem_r,   rem_nxt;
  logic [CNT_W-1:0]  bcnt_r;
  logic [POOL_W-1:0] pool_r;

  // Captured item
  logic              req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [POOL_W-1:0] owner_r;

  // Output register
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r,  status_nxt;
  logic [IDX_W-1:0]  gidx_r,    gidx_nxt;
  logic [POOL_W-1:0] gpool_r,   gpool_nxt;

  logic             link_we;
  logic [CNT_W-1:0] cfg_count;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      idx_r   <= in_block_index;
      owner_r <= in_owner_pool;
    end
  end

  // Link memory: write on release, registered read at the current head
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[idx_r] <= head_r;
    end
    rd_link_r <= link_mem[head_r[IDX_W-1:0]];
  end

  // Execute one request
  always_comb begin
    head_nxt   = head_r;
    fresh_nxt  = fresh_r;
    rem_nxt    = rem_r;
    status_nxt = ST_OK;
    gidx_nxt   = '0;
    gpool_nxt  = '0;
    link_we    = 1'b0;
    if (req_r == REQ_ALLOC) begin
      priority if (bcnt_r == '0) begin
        status_nxt = ST_NOT_INIT;
      end else if (rem_r == '0 || head_r >= bcnt_r) begin
        status_nxt = ST_EMPTY;
      end else begin
        // blocks at or above the fresh mark implicitly link to index+1
        if (head_r >= fresh_r) begin
          head_nxt = head_r + CNT_W'(1);
          if (head_r == fresh_r) begin
            fresh_nxt = head_r + CNT_W'(1);
          end
        end else begin
          head_nxt = rd_link_r;
        end
        rem_nxt   = rem_r - CNT_W'(1);
        gidx_nxt  = head_r[IDX_W-1:0];
        gpool_nxt = pool_r & POOL_MASK;
      end
    end else begin
      priority if ((owner_r & POOL_MASK) != (pool_r & POOL_MASK)) begin
        status_nxt = ST_WRONG_ID;
      end else if ({1'b0, idx_r} >= bcnt_r) begin
        status_nxt = ST_RANGE;
      end else begin
        link_we  = cmd.exec;
        head_nxt = {1'b0, idx_r};
        if (rem_r < MAX_CNT) begin
          rem_nxt = rem_r + CNT_W'(1);
        end
      end
    end
  end

  // Rebuild count saturates at the pool size
  assign cfg_count = (CNT_W'(cfg_wdata) > MAX_CNT) ? MAX_CNT : CNT_W'(cfg_wdata);

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fresh_r <= '0;
      rem_r   <= MAX_CNT;
      bcnt_r  <= MAX_CNT;
      pool_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: begin
          bcnt_r  <= cfg_count;
          rem_r   <= cfg_count;
          head_r  <= '0;
          fresh_r <= '0;
        end
        REG_POOL_ID: pool_r <= cfg_wdata[POOL_W-1:0];
        default: ;
      endcase
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      gidx_r   <= gidx_nxt;
      gpool_r  <= gpool_nxt;
    end
  end

  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = gidx_r;
  assign out_granted_pool  = gpool_r;
  assign out_free_count    = rem_r;

endmodule

FILE: src/fixed_block_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Flow: an item is captured as it is accepted in S_IDLE, then executed in
//   S_EXEC on the registered link read at the current head, which fills the
//   output register; no new item is accepted until the last one has executed,
//   and a result held by out_ready low stalls the next item.
// Reset (rst_n, synchronous): 1024 blocks, pool id 0, empty output register;
//   the link memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator_core: LIFO free list of fixed-size blocks
// Allocate pops the head block, release checks id and range and pushes it.
// ---------------------------------------------------------------------------
module fixed_block_free_list_allocator_core
  import fbfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  fbfla_req_if.sink         in_ch,
  fbfla_rsp_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  fbfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Free-list datapath
  fbfla_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_ch.req_type),
    .in_block_index    (in_ch.block_index),
    .in_owner_pool     (in_ch.owner_pool),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_granted_index (out_ch.granted_index),
    .out_granted_pool  (out_ch.granted_pool),
    .out_free_count    (out_ch.free_count)
  );

endmodule

FILE: dv/fixed_block_free_list_allocator_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator_core_tb: self-checking bench of the allocator
// Drives allocate and release items with random bursts and gaps, stalls the
// result side, and checks every result against a free-list tracker that
// mirrors the pool state, including the lazy initial chain and its end mark.
// ---------------------------------------------------------------------------
module fixed_block_free_list_allocator_core_tb;
  import fbfla_pkg::*;

  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int UNINIT_ITEMS   = 20;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  block_index;
    logic [POOL_W-1:0] owner_pool;
  } alloc_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_index;
    logic [POOL_W-1:0] granted_pool;
    logic [CNT_W-1:0]  free_count;
  } alloc_rsp_t;

  // Mirror of the pool state plus the queue of responses still owed
  class free_list_tracker;
    logic [CNT_W-1:0]  block_count;
    logic [POOL_W-1:0] pool_id;
    logic [CNT_W-1:0]  head;
    logic [CNT_W-1:0]  fresh_mark;
    logic [CNT_W-1:0]  remaining;
    logic [CNT_W-1:0]  link_mem [NUM_BLOCKS];
    bit                link_written [NUM_BLOCKS];
    logic [IDX_W-1:0]  held_blocks [$];
    alloc_rsp_t        owed_rsp [$];
    int                mismatches;
    int                checked;
    int                status_tally [5];

    function new();
      mismatches = 0;
      checked    = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      pool_id = '0;
      rebuild(CNT_W'(NUM_BLOCKS));
    endfunction

    // Writing block_count restarts the pool with the in-order chain
    function void rebuild(logic [CNT_W-1:0] count);
      block_count = (count > MAX_CNT) ? MAX_CNT : count;
      head        = '0;
      fresh_mark  = '0;
      remaining   = block_count;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        link_mem[i]     = '0;
        link_written[i] = 1'b0;
      end
      held_blocks.delete();
    endfunction

    function void set_pool(logic [POOL_W-1:0] id);
      pool_id = id;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    // True when a pop would follow a link that was never written
    function bit pop_hits_unwritten();
      return block_count != 0 && remaining != 0 && head < block_count &&
             head < fresh_mark && !link_written[head[IDX_W-1:0]];
    endfunction

    function void drop_held(logic [IDX_W-1:0] idx);
      for (int i = 0; i < held_blocks.size(); i++) begin
        if (held_blocks[i] == idx) begin
          held_blocks.delete(i);
          return;
        end
      end
    endfunction

    // Apply one accepted item and queue the response it owes
    function void note_request(alloc_req_t r);
      alloc_rsp_t       want;
      logic [CNT_W-1:0] h;
      logic [CNT_W-1:0] nxt;
      want = '0;
      if (r.req_type == REQ_ALLOC) begin
        if (block_count == 0) begin
          want.status = ST_NOT_INIT;
        end else if (remaining == 0 || head >= block_count) begin
          want.status = ST_EMPTY;
        end else begin
          h = head;
          // lazy chain: blocks at or above the mark link to index+1
          if (h >= fresh_mark) begin
            nxt = h + 1'b1;
            if (h == fresh_mark) fresh_mark = h + 1'b1;
          end else begin
            nxt = link_mem[h[IDX_W-1:0]];
          end
          head      = nxt;
          remaining = remaining - 1'b1;
          want.status        = ST_OK;
          want.granted_index = h[IDX_W-1:0];
          want.granted_pool  = pool_id & POOL_MASK;
          held_blocks.push_back(h[IDX_W-1:0]);
        end
      end else begin
        if ((r.owner_pool & POOL_MASK) != (pool_id & POOL_MASK)) begin
          want.status = ST_WRONG_ID;
        end else if ({1'b0, r.block_index} >= block_count) begin
          want.status = ST_RANGE;
        end else begin
          link_mem[r.block_index]     = head;
          link_written[r.block_index] = 1'b1;
          head = {1'b0, r.block_index};
          if (remaining < MAX_CNT) remaining = remaining + 1'b1;
          want.status = ST_OK;
          drop_held(r.block_index);
        end
      end
      want.free_count = remaining;
      owed_rsp.push_back(want);
    endfunction

    function void report(string what, alloc_rsp_t want, alloc_rsp_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"%s: expected status=%0d idx=%0d pool=%0d free=%0d, ",
                  "got status=%0d idx=%0d pool=%0d free=%0d"},
                 what, want.status, want.granted_index, want.granted_pool, want.free_count,
                 got.status, got.granted_index, got.granted_pool, got.free_count);
    endfunction

    function void check_response(alloc_rsp_t got);
      alloc_rsp_t want;
      if (owed_rsp.size() == 0) begin
        report("response with nothing outstanding", '0, got);
        return;
      end
      want = owed_rsp.pop_front();
      checked++;
      if (want.status < 5) status_tally[want.status]++;
      if (got.status != want.status || got.granted_index != want.granted_index ||
          got.granted_pool != want.granted_pool || got.free_count != want.free_count)
        report("response mismatch", want, got);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  fbfla_req_if in_ch();
  fbfla_rsp_if out_ch();

  fixed_block_free_list_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  free_list_tracker sb;
  bit gaps_on;
  bit hold_now;
  int burst_left;
  int items_sent;
  int cfg_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one item: optional gap between bursts, then hold until accepted
  task automatic send_item(input alloc_req_t r);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid       = 1'b1;
    in_ch.req_type    = r.req_type;
    in_ch.block_index = r.block_index;
    in_ch.owner_pool  = r.owner_pool;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic send_fields(input logic rt, input int idx, input int owner);
    alloc_req_t r;
    r.req_type    = rt;
    r.block_index = IDX_W'(idx);
    r.owner_pool  = POOL_W'(owner);
    send_item(r);
  endtask

  // Register write once the block has gone quiet
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int val);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DW'(val);
    @(posedge clk);
    if (idx == REG_BLOCK_COUNT) sb.rebuild(CNT_W'(val));
    else sb.set_pool(POOL_W'(val));
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed traffic: allocate, or release something we hold
  task automatic pick_request(output alloc_req_t r);
    int roll;
    int cnt;
    roll = $urandom_range(0, 99);
    cnt  = int'(sb.block_count);
    r.req_type    = REQ_ALLOC;
    r.block_index = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    r.owner_pool  = POOL_W'($urandom_range(0, 255));
    if (roll >= 50 && roll < 82 && sb.held_blocks.size() > 0) begin
      r.req_type    = REQ_RELEASE;
      r.block_index = sb.held_blocks[$urandom_range(0, sb.held_blocks.size() - 1)];
      r.owner_pool  = sb.pool_id;
    end else if (roll >= 50) begin
      r.req_type = REQ_RELEASE;
      case ($urandom_range(0, 3))
        0: r.owner_pool = sb.pool_id ^ POOL_W'($urandom_range(1, 255));
        1: begin
          r.owner_pool = sb.pool_id;
          if (cnt < NUM_BLOCKS) r.block_index = IDX_W'($urandom_range(cnt, NUM_BLOCKS - 1));
        end
        2: begin
          // release of a possibly free block: double release
          r.owner_pool = sb.pool_id;
          if (cnt > 0) r.block_index = IDX_W'($urandom_range(0, cnt - 1));
        end
        default: ;
      endcase
    end
    // never pop through a link the block was never given
    if (r.req_type == REQ_ALLOC && sb.pop_hits_unwritten()) begin
      r.req_type   = REQ_RELEASE;
      r.owner_pool = sb.pool_id;
      if (sb.held_blocks.size() > 0)
        r.block_index = sb.held_blocks[$urandom_range(0, sb.held_blocks.size() - 1)];
      else
        r.block_index = IDX_W'($urandom_range(0, cnt - 1));
    end
  endtask

  task automatic set_phase_config(input int p);
    write_reg(REG_POOL_ID, (p == 1) ? 255 : (p == 2) ? 0 : $urandom_range(0, 255));
    case (p)
      0:       write_reg(REG_BLOCK_COUNT, 8);
      1:       write_reg(REG_BLOCK_COUNT, NUM_BLOCKS);
      2:       write_reg(REG_BLOCK_COUNT, 3);
      3:       write_reg(REG_BLOCK_COUNT, 0);
      4:       write_reg(REG_BLOCK_COUNT, 16);
      5:       write_reg(REG_BLOCK_COUNT, 1);
      6:       write_reg(REG_BLOCK_COUNT, $urandom_range(512, NUM_BLOCKS));
      default: write_reg(REG_BLOCK_COUNT, $urandom_range(2, 64));
    endcase
  endtask

  // Result side: own stall pattern, plus one long hold-off on request
  initial begin
    int hold_left;
    int mode_left;
    int rx_mode;
    int rx_tick;
    hold_left    = 0;
    mode_left    = 0;
    rx_mode      = 0;
    rx_tick      = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_now) begin
        hold_now  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (rx_mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 1) != 0);
          2:       out_ch.ready = ($urandom_range(0, 7) != 0);
          default: out_ch.ready = (rx_tick % 4 != 3);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : rsp_monitor
    alloc_rsp_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status        = out_ch.status;
      got.granted_index = out_ch.granted_index;
      got.granted_pool  = out_ch.granted_pool;
      got.free_count    = out_ch.free_count;
      sb.check_response(got);
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    alloc_req_t r;
    int n;
    sb         = new();
    items_sent = 0;
    cfg_writes = 0;
    gaps_on    = 1'b1;
    hold_now   = 1'b0;
    burst_left = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_ALLOC;
    in_ch.block_index = '0;
    in_ch.owner_pool  = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_BLOCK_COUNT;
    cfg_wdata         = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: default pool, release above the fresh mark, end of list
    send_fields(REQ_RELEASE, 5, 0);        // full pool, count saturates
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_RELEASE, 6, 8'h80);    // wrong pool
    send_fields(REQ_RELEASE, 6, 0);
    send_fields(REQ_ALLOC, 0, 0);          // lazy link wins over stored one
    send_fields(REQ_RELEASE, 1023, 0);
    send_fields(REQ_ALLOC, 0, 0);          // head walks to the end mark
    send_fields(REQ_ALLOC, 0, 0);          // empty with blocks still counted
    send_fields(REQ_ALLOC, 1023, 255);

    // Not initialized pool
    write_reg(REG_BLOCK_COUNT, 0);
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_RELEASE, 0, 0);        // range check covers count 0
    send_fields(REQ_RELEASE, 1023, 1);

    // Single block, top pool id, double release
    write_reg(REG_POOL_ID, 255);
    write_reg(REG_BLOCK_COUNT, 1);
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_ALLOC, 0, 0);          // remaining is zero
    send_fields(REQ_RELEASE, 0, 255);
    send_fields(REQ_RELEASE, 0, 255);      // double release goes unnoticed
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_RELEASE, 1, 255);      // index equal to count
    send_fields(REQ_RELEASE, 1023, 8'h7F);

    // Oversized count saturates to the full pool
    write_reg(REG_BLOCK_COUNT, 2047);
    send_fields(REQ_ALLOC, 0, 0);
    send_fields(REQ_RELEASE, 1023, 255);

    // Random phases over a range of pool settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_phase_config(p);
      gaps_on = (p == PRESSURE_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (p == PRESSURE_PHASE) hold_now = 1'b1;
      n = (sb.block_count == 0) ? UNINIT_ITEMS : PHASE_ITEMS;
      repeat (n) begin
        pick_request(r);
        send_item(r);
      end
    end

    // Drain
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items across %0d register writes, %0d responses checked",
             items_sent, cfg_writes, sb.checked);
    $display("Status mix: ok %0d, empty %0d, wrong pool %0d, out of range %0d, not init %0d",
             sb.status_tally[ST_OK], sb.status_tally[ST_EMPTY], sb.status_tally[ST_WRONG_ID],
             sb.status_tally[ST_RANGE], sb.status_tally[ST_NOT_INIT]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
